/* rtl/vfe_pkg.sv */
// Package for the video-transmitter command frame encoder.
// Holds the request and result payload types, the queue entry type and frame constants.
// Depends on nothing; every other file of the block refers to it by scoped names.
package vfe_pkg;

    // Request payload as it arrives on the input channel.
    typedef struct packed {
        logic       mode;
        logic [6:0] cmd_id;
        logic [7:0] payload_len;
        logic [7:0] payload_byte;
    } in_item_t;

    // Result payload: one frame byte per transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    // Request modes.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    // Frame constants.
    localparam logic [7:0] FRAME_LEAD = 8'h00;
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    // Work kinds handed from the front to the back.
    typedef enum logic {
        OP_START,
        OP_PAYLOAD
    } op_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic [7:0] len;
        logic       last;
    } cmd_t;

    // Queue sizing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Byte sequencer steps of the back end.
    typedef enum logic [2:0] {
        STEP_FIRST,
        STEP_HDR1,
        STEP_HDR2,
        STEP_CMD,
        STEP_LEN,
        STEP_CRC
    } step_t;

endpackage

/* rtl/vfe_front.sv */
// Front end of the command frame encoder: accepts requests and classifies them.
// Tracks the open frame and its remaining payload count; depends on vfe_pkg.
module vfe_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  vfe_pkg::in_item_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output vfe_pkg::cmd_t    q_entry
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       accept;
    logic       is_start;

    // A request is taken whenever the queue has room.
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_start = (s_data.mode == vfe_pkg::MODE_START);

    // Classify the request and update the frame tracking state.
    always_comb begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        q_push          = 1'b0;
        q_entry.op      = is_start ? vfe_pkg::OP_START : vfe_pkg::OP_PAYLOAD;
        q_entry.arg     = is_start ? {s_data.cmd_id, 1'b1} : s_data.payload_byte;
        q_entry.len     = s_data.payload_len;
        q_entry.last    = is_start ? (s_data.payload_len == 8'd0)
                                   : (bytes_left_reg == 8'd1);
        if (accept) begin
            if (is_start) begin
                q_push          = 1'b1;
                frame_open_next = (s_data.payload_len != 8'd0);
                bytes_left_next = s_data.payload_len;
            end else if (frame_open_reg) begin
                q_push          = 1'b1;
                bytes_left_next = bytes_left_reg - 8'd1;
                frame_open_next = (bytes_left_reg != 8'd1);
            end
        end
    end

    // Frame tracking registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // A frame is open exactly while payload bytes are still owed.
    a_open_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_open_reg == (bytes_left_reg != 8'd0))
        else $error("frame_open disagrees with bytes_left");

endmodule

/* rtl/vfe_queue.sv */
// Short request queue between the front and back ends of the frame encoder.
// Register-based FIFO of classified requests; depends on vfe_pkg.
module vfe_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  vfe_pkg::cmd_t push_entry,
    input  logic          pop,
    output vfe_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    vfe_pkg::cmd_t                  mem [vfe_pkg::QUEUE_DEPTH];
    logic [vfe_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [vfe_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [vfe_pkg::QUEUE_CW-1:0]   count_reg, count_next;

    localparam logic [vfe_pkg::QUEUE_AW-1:0] LAST_PTR =
        vfe_pkg::QUEUE_AW'(vfe_pkg::QUEUE_DEPTH - 1);
    localparam logic [vfe_pkg::QUEUE_CW-1:0] FULL_COUNT =
        vfe_pkg::QUEUE_CW'(vfe_pkg::QUEUE_DEPTH);

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_COUNT);
    assign head  = mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

/* rtl/vfe_back.sv */
// Back end of the command frame encoder: byte sequencer, CRC-8 and output register.
// Emits one frame byte per cycle from the queue head unless stalled; depends on vfe_pkg.
module vfe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  vfe_pkg::cmd_t      q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vfe_pkg::out_item_t m_data
);

    vfe_pkg::step_t     step_reg, step_next;
    logic [7:0]         crc_reg, crc_next;
    logic               out_valid_reg, out_valid_next;
    vfe_pkg::out_item_t out_data_reg, out_data_next;
    logic               load;
    logic               active;
    logic [7:0]         emit_byte;
    logic               emit_end;
    logic               covered;
    logic               crc_clear;
    logic               final_step;

    // One CRC-8 byte update, MSB first.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ vfe_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // The output register takes a byte when it is empty or being drained.
    assign load   = !out_valid_reg || m_ready;
    assign active = !q_empty && load;
    assign q_pop  = active && final_step;

    // Step decode: byte to send, CRC handling and the following step.
    always_comb begin
        emit_byte  = vfe_pkg::FRAME_LEAD;
        emit_end   = 1'b0;
        covered    = 1'b0;
        crc_clear  = 1'b0;
        final_step = 1'b0;
        step_next  = step_reg;
        unique case (step_reg)
            vfe_pkg::STEP_FIRST: begin
                if (q_head.op == vfe_pkg::OP_START) begin
                    emit_byte = vfe_pkg::FRAME_LEAD;
                    crc_clear = 1'b1;
                    step_next = vfe_pkg::STEP_HDR1;
                end else begin
                    emit_byte  = q_head.arg;
                    covered    = 1'b1;
                    final_step = !q_head.last;
                    step_next  = q_head.last ? vfe_pkg::STEP_CRC : vfe_pkg::STEP_FIRST;
                end
            end
            vfe_pkg::STEP_HDR1: begin
                emit_byte = vfe_pkg::HDR_FIRST;
                covered   = 1'b1;
                step_next = vfe_pkg::STEP_HDR2;
            end
            vfe_pkg::STEP_HDR2: begin
                emit_byte = vfe_pkg::HDR_SECOND;
                covered   = 1'b1;
                step_next = vfe_pkg::STEP_CMD;
            end
            vfe_pkg::STEP_CMD: begin
                emit_byte = q_head.arg;
                covered   = 1'b1;
                step_next = vfe_pkg::STEP_LEN;
            end
            vfe_pkg::STEP_LEN: begin
                emit_byte  = q_head.len;
                covered    = 1'b1;
                final_step = !q_head.last;
                step_next  = q_head.last ? vfe_pkg::STEP_CRC : vfe_pkg::STEP_FIRST;
            end
            vfe_pkg::STEP_CRC: begin
                emit_byte  = crc_reg;
                emit_end   = 1'b1;
                final_step = 1'b1;
                step_next  = vfe_pkg::STEP_FIRST;
            end
            default: begin
                step_next = vfe_pkg::STEP_FIRST;
            end
        endcase
    end

    // Next values of the sequencer, the CRC and the output register.
    always_comb begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (active) begin
            if (crc_clear) begin
                crc_next = 8'd0;
            end else if (covered) begin
                crc_next = crc_update(crc_reg, emit_byte);
            end
            out_valid_next          = 1'b1;
            out_data_next.out_byte  = emit_byte;
            out_data_next.frame_end = emit_end;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= vfe_pkg::STEP_FIRST;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= active ? step_next : step_reg;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A request in progress stays at the queue head until its last byte.
    a_busy_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != vfe_pkg::STEP_FIRST) |-> !q_empty)
        else $error("sequencer mid-request with an empty queue");

    // A frame end byte is only ever loaded from the CRC step.
    a_end_from_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (active && emit_end) |-> (step_reg == vfe_pkg::STEP_CRC) && q_pop)
        else $error("frame end outside the CRC step");

endmodule

/* rtl/vtx_command_frame_encoder_unit.sv */
// Path: an accepted request, unless a payload request with no frame open, is written into a
// queue entry; at the queue head its first byte enters the m_data output register once free.
// Throughput: one byte per cycle unless stalled by m_ready or an empty queue; a start request
// yields five bytes, or six with its CRC byte, a payload request one, or two with the CRC byte.
// A four-entry queue lets the front keep accepting requests while the back sequences bytes.
// Reset: synchronous, active-low aresetn clears the queue, frame state, CRC and output valid.
module vtx_command_frame_encoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vfe_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vfe_pkg::out_item_t m_data
);

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    vfe_pkg::cmd_t q_entry;
    vfe_pkg::cmd_t q_head;

    // Request classification and frame tracking.
    vfe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Queue between the two ends.
    vfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Byte sequencing, CRC and result register.
    vfe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the video-transmitter command frame encoder.
// Predicts every frame byte and its CRC-8 from the accepted requests and checks each result.
// Depends on vfe_pkg and vtx_command_frame_encoder_unit.
`timescale 1ns / 100ps

module tb;

    // Expected-byte tracker: models the frame builder and holds the bytes still owed.
    class frame_byte_tracker;
        logic [7:0]         crc;
        logic [7:0]         left;
        logic               open;
        vfe_pkg::out_item_t owed[$];
        int                 errors;

        function new();
            crc    = 8'h00;
            left   = 8'h00;
            open   = 1'b0;
            errors = 0;
        endfunction

        // CRC-8, polynomial 0xD5, MSB first, one byte at a time.
        function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] v;
            v = c ^ b;
            for (int i = 0; i < 8; i++) begin
                v = v[7] ? ((v << 1) ^ vfe_pkg::CRC_POLY) : (v << 1);
            end
            return v;
        endfunction

        function void owe(logic [7:0] b, logic last, logic covered);
            vfe_pkg::out_item_t o;
            o.out_byte  = b;
            o.frame_end = last;
            owed.insert(owed.size(), o);
            if (covered) begin
                crc = crc8_next(crc, b);
            end
        endfunction

        // Notes an accepted request; returns the number of bytes it will produce.
        function int note_request(vfe_pkg::in_item_t r);
            int n;
            n = owed.size();
            if (r.mode == vfe_pkg::MODE_START) begin
                // A start drops any open frame and begins a fresh one.
                crc = 8'h00;
                owe(vfe_pkg::FRAME_LEAD, 1'b0, 1'b0);
                owe(vfe_pkg::HDR_FIRST, 1'b0, 1'b1);
                owe(vfe_pkg::HDR_SECOND, 1'b0, 1'b1);
                owe({r.cmd_id, 1'b1}, 1'b0, 1'b1);
                owe(r.payload_len, 1'b0, 1'b1);
                if (r.payload_len == 8'h00) begin
                    owe(crc, 1'b1, 1'b0);
                    open = 1'b0;
                    left = 8'h00;
                end else begin
                    open = 1'b1;
                    left = r.payload_len;
                end
            end else if (open) begin
                owe(r.payload_byte, 1'b0, 1'b1);
                left = left - 8'd1;
                if (left == 8'h00) begin
                    owe(crc, 1'b1, 1'b0);
                    open = 1'b0;
                end
            end
            return owed.size() - n;
        endfunction

        // Compares one accepted result with the oldest owed byte.
        function void check_byte(vfe_pkg::out_item_t got);
            vfe_pkg::out_item_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result byte %h frame_end %b",
                         $time, got.out_byte, got.frame_end);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte mismatch, expected %h, actual %h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end mismatch, expected %b, actual %b",
                         $time, want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    vfe_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    vfe_pkg::out_item_t m_data;

    frame_byte_tracker tracker;
    int                accepted_count = 0;
    int                quiet_cycles = 0;
    bit                calm;

    vtx_command_frame_encoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Result side: m_ready is low with 18 percent probability, never during the calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99, 0) >= 18);
        end
    end

    // Monitor: notes accepted requests and checks accepted results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                void'(tracker.note_request(s_data));
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                tracker.check_byte(m_data);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= 2000) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic vfe_pkg::in_item_t make_request(logic mode, logic [6:0] code,
                                                       logic [7:0] len, logic [7:0] pb);
        vfe_pkg::in_item_t r;
        r.mode         = mode;
        r.cmd_id       = code;
        r.payload_len  = len;
        r.payload_byte = pb;
        return r;
    endfunction

    // Presents one request, with random idle cycles ahead of it outside the calm stretch, and waits for acceptance.
    task automatic send_request(vfe_pkg::in_item_t r);
        while (!calm && $urandom_range(99, 0) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_start(logic [6:0] code, logic [7:0] len, logic [7:0] pb);
        send_request(make_request(vfe_pkg::MODE_START, code, len, pb));
    endtask

    task automatic send_payload(logic [7:0] pb, logic [6:0] code, logic [7:0] len);
        send_request(make_request(vfe_pkg::MODE_PAYLOAD, code, len, pb));
    endtask

    // Holds the sender off until every owed byte has been received.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.owed.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One random frame: mostly complete, sometimes cut short by the next start.
    task automatic random_frame();
        int         pick;
        int         len;
        int         sent;
        logic [6:0] code;
        pick = $urandom_range(99, 0);
        code = 7'($urandom_range(127, 0));
        if (pick < 60) begin
            len = $urandom_range(6, 0);
        end else if (pick < 85) begin
            len = $urandom_range(24, 7);
        end else begin
            len = $urandom_range(255, 0);
        end
        sent = len;
        if (len > 24 || $urandom_range(99, 0) < 10) begin
            sent = (len == 0) ? 0 : $urandom_range((len > 10) ? 10 : len - 1, 0);
        end
        send_start(code, 8'(len), 8'($urandom_range(255, 0)));
        for (int i = 0; i < sent; i++) begin
            send_payload(8'($urandom_range(255, 0)), 7'($urandom_range(127, 0)),
                         8'($urandom_range(255, 0)));
        end
    endtask

    initial begin
        int n_random;
        tracker = new();
        calm    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // Payload with no frame open is dropped.
        send_payload(8'h3C, 7'h00, 8'h00);
        // Zero-length frames at both ends of the command code range.
        send_start(7'h00, 8'h00, 8'h00);
        send_start(7'h7F, 8'h00, 8'hFF);
        // Short complete frames with extreme payload bytes.
        send_start(7'h55, 8'h01, 8'h00);
        send_payload(8'h00, 7'h00, 8'h00);
        send_start(7'h2A, 8'h02, 8'h00);
        send_payload(8'hFF, 7'h00, 8'h00);
        send_payload(8'h80, 7'h00, 8'h00);
        // Longest frame, abandoned by a new start, which is itself abandoned.
        send_start(7'h01, 8'hFF, 8'h00);
        send_payload(8'hA5, 7'h00, 8'h00);
        send_payload(8'h5A, 7'h00, 8'h00);
        send_start(7'h40, 8'h80, 8'h00);
        send_payload(8'h01, 7'h00, 8'h00);
        // Unused fields set on every item must be ignored.
        send_start(7'h3F, 8'h03, 8'hFF);
        send_payload(8'h7F, 7'h7F, 8'hFF);
        send_payload(8'hFE, 7'h7F, 8'hFF);
        send_payload(8'h0F, 7'h7F, 8'hFF);
        // Frame is closed now, so this is dropped.
        send_payload(8'hFF, 7'h7F, 8'hFF);
        wait_drained();

        // Random part: random frames, some cut short, with occasional stray payload requests.
        n_random = 0;
        while (accepted_count < 305) begin
            calm = (n_random >= 30 && n_random < 42);
            if ($urandom_range(99, 0) < 15) begin
                send_payload(8'($urandom_range(255, 0)), 7'($urandom_range(127, 0)),
                             8'($urandom_range(255, 0)));
            end else begin
                random_frame();
            end
            n_random++;
            if (n_random == 20) begin
                wait_drained();
            end
        end
        calm = 1'b0;

        // Drain and allow for the pipeline latency.
        wait_drained();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
